// ----- design/ssu_pkg.sv -----
// Shared types and constants for the sorted integer set unit.
package ssu_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 4;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic [1:0] {
        REQ_CHECK = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_DEL   = 2'd2,
        REQ_READ  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_INDEX = 2'd2
    } status_t;

    typedef struct packed {
        logic ins_en;
        logic del_en;
    } cell_ctrl_t;

endpackage

// ----- design/ssu_cell.sv -----
// One storage cell of the sorted element row.
module ssu_cell
    import ssu_pkg::*;
(
    input  logic       clk,
    input  logic       valid,
    input  data_t      value,
    input  cell_ctrl_t ctrl,
    input  data_t      prev_elem,
    input  logic       prev_lt,
    input  data_t      next_elem,
    output data_t      elem,
    output logic       lt,
    output logic       eq
);

    data_t elem_reg;
    data_t elem_next;

    assign elem = elem_reg;
    assign lt   = valid && ($signed(elem_reg) < $signed(value));
    assign eq   = valid && (elem_reg == value);

    always_comb
    begin
        elem_next = elem_reg;
        if (ctrl.ins_en && !lt)
        begin
            elem_next = prev_lt ? value : prev_elem;
        end
        else if (ctrl.del_en && !lt)
        begin
            elem_next = next_elem;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

endmodule

// ----- design/sorted_integer_set_unit.sv -----
// Top level of the sorted integer set unit.
//
// Usage: drive req_type, value and position and raise start; a transaction
// is taken at a rising edge with start high and busy low. busy stays low,
// so a new transaction may be issued in every cycle.
// The result (was_present, element_count, status, read_value) is registered
// at the accepting edge and marked by done for exactly one cycle.
// Throughput is 1 transaction per cycle: a row of CAPACITY cells compares
// every element against value at once and shifts toward or away from the
// insert or delete point in the same cycle.
// The receiver cannot stall; each result must be taken in its done cycle.
// Reset clears the element count and the output strobe; cell contents are
// left as they are and never read until written.
// Type 3 reads the element at position; a position at or beyond the count
// gives status bad index and read_value zero. Adding a new value to a full
// set is refused with status full.
module sorted_integer_set_unit
    import ssu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] value,
    input  logic [3:0]  position,
    output logic        done,
    output logic        was_present,
    output logic [4:0]  element_count,
    output logic [1:0]  status,
    output logic [31:0] read_value
);

    count_t     count_reg;
    count_t     count_next;
    logic       done_reg;
    logic       present_reg;
    status_t    status_reg;
    status_t    status_next;
    data_t      rd_reg;
    data_t      rd_next;

    logic       accept;
    req_type_t  req;
    cell_ctrl_t ctrl;
    logic       present;
    logic       full;
    logic       pos_ok;

    data_t      elem [CAPACITY];
    logic       lt   [CAPACITY];
    logic       eq   [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign req    = req_type_t'(req_type);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            ssu_cell u_cell (
                .clk       (clk),
                .valid     (count_t'(gi) < count_reg),
                .value     (value),
                .ctrl      (ctrl),
                .prev_elem ((gi == 0) ? value : elem[(gi == 0) ? 0 : gi - 1]),
                .prev_lt   ((gi == 0) ? 1'b1 : lt[(gi == 0) ? 0 : gi - 1]),
                .next_elem ((gi == CAPACITY - 1) ? elem[gi]
                                                 : elem[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .elem      (elem[gi]),
                .lt        (lt[gi]),
                .eq        (eq[gi])
            );
            assign eq_vec[gi] = eq[gi];
        end
    endgenerate

    assign present = |eq_vec;
    assign full    = (count_reg == count_t'(CAPACITY));
    assign pos_ok  = (CMP_W'(position) < CMP_W'(count_reg))
                  && (CMP_W'(position) < CMP_W'(CAPACITY));

    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = STAT_OK;
        rd_next     = '0;
        if (accept)
        begin
            unique case (req)
                REQ_CHECK:
                begin
                end
                REQ_ADD:
                begin
                    if (!present)
                    begin
                        if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            ctrl.ins_en = 1'b1;
                            count_next  = count_reg + count_t'(1);
                        end
                    end
                end
                REQ_DEL:
                begin
                    if (present)
                    begin
                        ctrl.del_en = 1'b1;
                        count_next  = count_reg - count_t'(1);
                    end
                end
                REQ_READ:
                begin
                    if (pos_ok)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (CMP_W'(position) == CMP_W'(i))
                            begin
                                rd_next = elem[i];
                            end
                        end
                    end
                    else
                    begin
                        status_next = STAT_BAD_INDEX;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            present_reg <= present;
            status_reg  <= status_next;
            rd_reg      <= rd_next;
        end
    end

    assign done          = done_reg;
    assign was_present   = present_reg;
    assign element_count = 5'(count_reg);
    assign status        = status_reg;
    assign read_value    = rd_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(CAPACITY))
        else $error("element count above capacity");

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after accepted transaction");

    a_count_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("element count changed without a transaction");

    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == STAT_FULL) |-> (count_reg == count_t'(CAPACITY)))
        else $error("add refused while set not full");
`endif

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the sorted integer set unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssu_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int POOL_N     = 24;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 50;

    typedef struct {
        logic        was_present;
        logic [4:0]  element_count;
        status_t     status;
        data_t       read_value;
    } set_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [31:0] value;
    logic [3:0]  position;
    logic        done;
    logic        was_present;
    logic [4:0]  element_count;
    logic [1:0]  status;
    logic [31:0] read_value;

    data_t       set_elems [CAPACITY];
    int          set_count;
    set_result_t predicted_results [$];
    data_t       value_pool [POOL_N];

    int          mismatches;
    int          idle_cycles;
    int          type_seen [4];
    int          full_refusals;
    int          bad_reads;
    int          hits;

    sorted_integer_set_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .value         (value),
        .position      (position),
        .done          (done),
        .was_present   (was_present),
        .element_count (element_count),
        .status        (status),
        .read_value    (read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic set_result_t set_apply(input req_type_t rt, input data_t v,
                                              input logic [3:0] pos);
        set_result_t r;
        int          below;
        logic        present;
        below = 0;
        for (int i = 0; i < set_count; i++)
            if ($signed(set_elems[i]) < $signed(v))
                below++;
        present = (below < set_count) && (set_elems[below] == v);
        r.status = STAT_OK;
        r.read_value = '0;
        case (rt)
            REQ_ADD:
                if (!present)
                begin
                    if (set_count >= CAPACITY)
                        r.status = STAT_FULL;
                    else
                    begin
                        for (int i = set_count; i > below; i--)
                            set_elems[i] = set_elems[i-1];
                        set_elems[below] = v;
                        set_count++;
                    end
                end
            REQ_DEL:
                if (present)
                begin
                    for (int i = below; i + 1 < set_count; i++)
                        set_elems[i] = set_elems[i+1];
                    set_count--;
                end
            REQ_READ:
                if (int'(pos) < set_count)
                    r.read_value = set_elems[pos];
                else
                    r.status = STAT_BAD_INDEX;
            default: ;
        endcase
        r.was_present = present;
        r.element_count = 5'(set_count);
        return r;
    endfunction

    // Check each result against the oldest prediction, then predict any new transaction.
    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing pending, got pres=%b cnt=%0d st=%0d rd=%h",
                                 $realtime, was_present, element_count, status,
                                 read_value);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (was_present !== want.was_present
                        || element_count !== want.element_count
                        || status !== want.status
                        || read_value !== want.read_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch want pres=%b cnt=%0d st=%0d rd=%h,",
                                      " got pres=%b cnt=%0d st=%0d rd=%h"},
                                     $realtime, want.was_present, want.element_count,
                                     want.status, want.read_value, was_present,
                                     element_count, status, read_value);
                    end
                end
            end
            if (start && !busy)
            begin
                want = set_apply(req_type_t'(req_type), value, position);
                predicted_results.push_back(want);
                type_seen[req_type]++;
                if (want.status == STAT_FULL)
                    full_refusals++;
                if (want.status == STAT_BAD_INDEX)
                    bad_reads++;
                if (want.was_present)
                    hits++;
            end
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return $urandom_range(0, 15);
    endfunction

    task automatic send_req(input req_type_t rt, input data_t v, input logic [3:0] pos,
                            input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= rt;
        value    <= v;
        position <= pos;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_req(REQ_READ,  32'h0,        4'd0,  draw_gap());
        send_req(REQ_READ,  32'h0,        4'd15, draw_gap());
        send_req(REQ_CHECK, 32'h0,        4'd0,  draw_gap());
        send_req(REQ_DEL,   32'h5,        4'd0,  draw_gap());
        send_req(REQ_ADD,   32'h0,        4'd0,  draw_gap());
        send_req(REQ_ADD,   32'h7FFFFFFF, 4'd0,  draw_gap());
        send_req(REQ_ADD,   32'h80000000, 4'd0,  draw_gap());
        send_req(REQ_ADD,   32'hFFFFFFFF, 4'd0,  draw_gap());
        send_req(REQ_ADD,   32'h1,        4'd0,  draw_gap());
        send_req(REQ_ADD,   32'h0,        4'd0,  draw_gap());
        send_req(REQ_READ,  32'h0,        4'd0,  draw_gap());
        send_req(REQ_READ,  32'h0,        4'd4,  draw_gap());
        send_req(REQ_READ,  32'h0,        4'd5,  draw_gap());
        send_req(REQ_CHECK, 32'hFFFFFFFF, 4'd0,  draw_gap());
        send_req(REQ_READ,  32'h1,        4'd2,  draw_gap());
        send_req(REQ_DEL,   32'hFFFFFFFF, 4'd0,  draw_gap());
        send_req(REQ_DEL,   32'hFFFFFFFF, 4'd0,  draw_gap());
        send_req(REQ_CHECK, 32'hFFFFFFFF, 4'd0,  draw_gap());
        send_req(REQ_READ,  32'h7FFFFFFF, 4'd15, draw_gap());
        drain();
    endtask

    task automatic test_full_set();
        for (int i = 0; i < CAPACITY; i++)
            send_req(REQ_ADD, data_t'(32'h1000 * i - 32'h8000), 4'd0, 0);
        send_req(REQ_ADD,   32'h12345678, 4'd0,  draw_gap());
        send_req(REQ_ADD,   32'h0,        4'd0,  draw_gap());
        send_req(REQ_READ,  32'h0,        4'd15, draw_gap());
        send_req(REQ_DEL,   32'h0,        4'd0,  draw_gap());
        send_req(REQ_ADD,   32'h12345678, 4'd0,  draw_gap());
        send_req(REQ_ADD,   32'h0,        4'd0,  draw_gap());
        drain();
    endtask

    task automatic test_random();
        req_type_t rt;
        data_t     v;
        int        roll;
        int        gap;
        value_pool[0] = 32'h80000000;
        value_pool[1] = 32'h7FFFFFFF;
        value_pool[2] = 32'h0;
        value_pool[3] = 32'hFFFFFFFF;
        value_pool[4] = 32'h1;
        value_pool[5] = 32'h80000001;
        value_pool[6] = 32'h7FFFFFFE;
        for (int i = 7; i < POOL_N; i++)
            value_pool[i] = $urandom;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                roll = $urandom_range(0, 99);
                // Alternate phases that grow the set toward full and shrink it toward empty.
                if (roll < 50)
                    rt = (ph % 2 == 0) ? REQ_ADD : REQ_DEL;
                else if (roll < 65)
                    rt = (ph % 2 == 0) ? REQ_DEL : REQ_ADD;
                else if (roll < 80)
                    rt = REQ_CHECK;
                else
                    rt = REQ_READ;
                v = ($urandom_range(0, 3) != 0) ? value_pool[$urandom_range(0, POOL_N-1)]
                                                : data_t'($urandom);
                gap = (ph % 3 == 0) ? 0 : draw_gap();
                send_req(rt, v, 4'($urandom_range(0, 15)), gap);
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        req_type   <= REQ_CHECK;
        value      <= '0;
        position   <= '0;
        mismatches  = 0;
        idle_cycles = 0;
        set_count   = 0;
        full_refusals = 0;
        bad_reads   = 0;
        hits        = 0;
        for (int i = 0; i < 4; i++)
            type_seen[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_set();
        test_random();

        drain();
        repeat (4) @(posedge clk);
        $display("Covered %0d checks, %0d adds, %0d deletes, %0d reads.",
                 type_seen[REQ_CHECK], type_seen[REQ_ADD], type_seen[REQ_DEL],
                 type_seen[REQ_READ]);
        $display("Saw %0d refused adds, %0d out-of-range reads, %0d hits; %0d mismatches.",
                 full_refusals, bad_reads, hits, mismatches);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
